// File: hw/rtl/tlvp_pkg.sv
// Shared types and constants for the TLV field stream parser.
package tlvp_pkg;

    // Field widths
    localparam int unsigned ID_W    = 9;
    localparam int unsigned TYPE_W  = 4;
    localparam int unsigned SIZE_W  = 11;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned MASK_W  = 16;
    localparam int unsigned TABLE_W = 64;
    localparam int unsigned FIX_W   = 4;   // bits per fixed-size table entry
    localparam int unsigned HI_W    = 3;   // high size bits carried in the header
    localparam int unsigned ODATA_W = ID_W + TYPE_W + SIZE_W + BYTE_W;
    localparam int unsigned OUSER_W = 2;

    // Configuration register indexes
    localparam logic CFG_VAR_MASK    = 1'b0;
    localparam logic CFG_FIXED_TABLE = 1'b1;

    // Parse phase
    typedef enum logic [1:0] {
        PH_HDR0,    // expect first header byte
        PH_HDR1,    // expect second header byte
        PH_SIZE,    // expect low size byte
        PH_DATA     // payload bytes
    } t_phase;

    // One result beat
    typedef struct packed {
        logic [ID_W-1:0]   field_id;
        logic [TYPE_W-1:0] field_type;
        logic [SIZE_W-1:0] field_size;
        logic [BYTE_W-1:0] data_byte;
        logic              byte_valid;
        logic              field_last;
        logic              parse_error;
    } t_result;

endpackage

// File: hw/rtl/tlv_field_stream_parser.sv
// TLV field stream parser: byte stream in, tagged payload bytes out.
//
//  Channel   Dir  tdata                                   tuser                   tlast
//  s_axis    in   [7:0] in_byte                           -                       buffer_end
//  m_axis    out  [8:0] id [12:9] type [23:13] size       [0] byte_valid          field_last
//                 [31:24] data_byte                       [1] parse_error
//  cfg       in   i_cfg_addr 0: type mask, 1: fixed size table (i_cfg_data)
//
//  One input beat per cycle while s_axis_tready is high; a result appears on m_axis the cycle after its beat.
//  The phase update and result forming sit between the input beat and the output register.
//  The input accepts whenever the output register is empty or is being drained.
//  Synchronous active-low reset clears the parse state, output valid and configuration.
//  A buffer end always returns to header parsing, so no error state outlives a buffer.
module tlv_field_stream_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_addr,
    input  logic [tlvp_pkg::TABLE_W-1:0]        i_cfg_data,
    // input byte stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [tlvp_pkg::BYTE_W-1:0]         s_axis_tdata,   // [7:0] in_byte
    input  logic                                s_axis_tlast,   // buffer_end
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [tlvp_pkg::ODATA_W-1:0]        m_axis_tdata,   // id, type, size, data_byte
    output logic [tlvp_pkg::OUSER_W-1:0]        m_axis_tuser,   // byte_valid, parse_error
    output logic                                m_axis_tlast    // field_last
);

    // Configuration registers
    logic [tlvp_pkg::MASK_W-1:0]  r_var_mask;
    logic [tlvp_pkg::TABLE_W-1:0] r_fixed_table;

    // Parse state
    tlvp_pkg::t_phase              r_phase, n_phase;
    logic [tlvp_pkg::BYTE_W-1:0]   r_header_high, n_header_high;
    logic [tlvp_pkg::ID_W-1:0]     r_cur_id, n_cur_id;
    logic [tlvp_pkg::TYPE_W-1:0]   r_cur_type, n_cur_type;
    logic [tlvp_pkg::SIZE_W-1:0]   r_cur_size, n_cur_size;
    logic [tlvp_pkg::SIZE_W-1:0]   r_bytes_left, n_bytes_left;

    // Output register
    logic                          r_out_valid;
    tlvp_pkg::t_result             r_out, n_out;
    logic                          n_emit;

    // Decode helpers
    logic                          in_beat;
    logic [2*tlvp_pkg::BYTE_W-1:0] hdr;
    logic [tlvp_pkg::ID_W-1:0]     hdr_id;
    logic [tlvp_pkg::TYPE_W-1:0]   hdr_type;
    logic                          hdr_var;
    logic [tlvp_pkg::SIZE_W-1:0]   hdr_fixed_size;
    logic [tlvp_pkg::SIZE_W-1:0]   size_full;
    logic [tlvp_pkg::SIZE_W-1:0]   left_dec;
    logic                          data_last;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    assign hdr            = {r_header_high, s_axis_tdata};
    assign hdr_id         = hdr[15:7];
    assign hdr_type       = hdr[6:3];
    assign hdr_var        = r_var_mask[hdr_type];
    assign hdr_fixed_size = {{(tlvp_pkg::SIZE_W-tlvp_pkg::FIX_W){1'b0}},
                             r_fixed_table[{hdr_type, 2'b00} +: tlvp_pkg::FIX_W]};
    assign size_full      = {r_cur_size[tlvp_pkg::SIZE_W-1 -: tlvp_pkg::HI_W], s_axis_tdata};
    assign left_dec       = r_bytes_left - tlvp_pkg::SIZE_W'(1);
    assign data_last      = (left_dec == '0);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_var_mask    <= '0;
            r_fixed_table <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tlvp_pkg::CFG_VAR_MASK:    r_var_mask    <= i_cfg_data[tlvp_pkg::MASK_W-1:0];
                tlvp_pkg::CFG_FIXED_TABLE: r_fixed_table <= i_cfg_data;
                default:                   r_var_mask    <= r_var_mask;
            endcase
        end
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (in_beat) begin
            unique case (r_phase)
                tlvp_pkg::PH_HDR0: n_phase = tlvp_pkg::PH_HDR1;
                tlvp_pkg::PH_HDR1: begin
                    if (hdr_var) begin
                        n_phase = tlvp_pkg::PH_SIZE;
                    end else if (hdr_fixed_size == '0) begin
                        n_phase = tlvp_pkg::PH_HDR0;
                    end else begin
                        n_phase = tlvp_pkg::PH_DATA;
                    end
                end
                tlvp_pkg::PH_SIZE: begin
                    n_phase = (size_full == '0) ? tlvp_pkg::PH_HDR0 : tlvp_pkg::PH_DATA;
                end
                tlvp_pkg::PH_DATA: begin
                    if (data_last) begin
                        n_phase = tlvp_pkg::PH_HDR0;
                    end
                end
                default: n_phase = tlvp_pkg::PH_HDR0;
            endcase
            // every buffer starts afresh
            if (s_axis_tlast) begin
                n_phase = tlvp_pkg::PH_HDR0;
            end
        end
    end

    // Field state and result forming
    always_comb begin
        n_header_high = r_header_high;
        n_cur_id      = r_cur_id;
        n_cur_type    = r_cur_type;
        n_cur_size    = r_cur_size;
        n_bytes_left  = r_bytes_left;
        n_emit        = 1'b0;
        n_out         = '0;
        if (in_beat) begin
            unique case (r_phase)
                tlvp_pkg::PH_HDR0: begin
                    n_header_high = s_axis_tdata;
                    // buffer ends inside the header
                    n_emit            = s_axis_tlast;
                    n_out.parse_error = 1'b1;
                end
                tlvp_pkg::PH_HDR1: begin
                    n_cur_id         = hdr_id;
                    n_cur_type       = hdr_type;
                    n_out.field_id   = hdr_id;
                    n_out.field_type = hdr_type;
                    if (hdr_var) begin
                        n_cur_size = {hdr[2:0], {tlvp_pkg::BYTE_W{1'b0}}};
                        // size byte still missing
                        n_emit            = s_axis_tlast;
                        n_out.parse_error = 1'b1;
                    end else begin
                        n_cur_size   = hdr_fixed_size;
                        n_bytes_left = hdr_fixed_size;
                        if (hdr_fixed_size == '0) begin
                            n_emit           = 1'b1;
                            n_out.field_last = 1'b1;
                        end else begin
                            n_emit            = s_axis_tlast;
                            n_out.field_size  = hdr_fixed_size;
                            n_out.parse_error = 1'b1;
                        end
                    end
                end
                tlvp_pkg::PH_SIZE: begin
                    n_cur_size       = size_full;
                    n_bytes_left     = size_full;
                    n_out.field_id   = r_cur_id;
                    n_out.field_type = r_cur_type;
                    if (size_full == '0) begin
                        n_emit           = 1'b1;
                        n_out.field_last = 1'b1;
                    end else begin
                        n_emit            = s_axis_tlast;
                        n_out.field_size  = size_full;
                        n_out.parse_error = 1'b1;
                    end
                end
                tlvp_pkg::PH_DATA: begin
                    n_bytes_left      = left_dec;
                    n_emit            = 1'b1;
                    n_out.field_id    = r_cur_id;
                    n_out.field_type  = r_cur_type;
                    n_out.field_size  = r_cur_size;
                    n_out.data_byte   = s_axis_tdata;
                    n_out.byte_valid  = 1'b1;
                    n_out.field_last  = data_last;
                    n_out.parse_error = s_axis_tlast && !data_last;
                end
                default: n_emit = 1'b0;
            endcase
        end
    end

    // State and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= tlvp_pkg::PH_HDR0;
            r_header_high <= '0;
            r_cur_id      <= '0;
            r_cur_type    <= '0;
            r_cur_size    <= '0;
            r_bytes_left  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_header_high <= n_header_high;
            r_cur_id      <= n_cur_id;
            r_cur_type    <= n_cur_type;
            r_cur_size    <= n_cur_size;
            r_bytes_left  <= n_bytes_left;
            if (s_axis_tready) begin
                r_out_valid <= n_emit;
            end
        end
    end

    // Result register, loaded only with a new result
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && n_emit) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.data_byte, r_out.field_size, r_out.field_type, r_out.field_id};
    assign m_axis_tuser  = {r_out.parse_error, r_out.byte_valid};
    assign m_axis_tlast  = r_out.field_last;

endmodule
